// ===== hdl/pcf_pkg.sv =====
`default_nettype none

package pcf_pkg;

  localparam int PAIR_COUNT = 4;
  localparam int RING_BYTES = 256;

  localparam int PAIR_IW    = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int STORE_DEPTH = PAIR_COUNT * RING_BYTES;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  typedef logic [PAIR_IW-1:0] pidx_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  localparam ptr_t FULL_FILL = PTR_W'(RING_BYTES - 1);

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_MWRITE = 3'd1,
    OP_SWRITE = 3'd2,
    OP_MREAD  = 3'd3,
    OP_SREAD  = 3'd4,
    OP_MCLOSE = 3'd5,
    OP_SCLOSE = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_BAD_PAIR    = 3'd1,
    STAT_OWN_CLOSED  = 3'd2,
    STAT_PEER_CLOSED = 3'd3,
    STAT_WOULD_BLOCK = 3'd4,
    STAT_EMPTY       = 3'd5,
    STAT_FULL        = 3'd6,
    STAT_NONE_FREE   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LF,
    S_RESP
  } state_e;

  function automatic addr_t addr_of(input pidx_t pair, input ptr_t ptr);
    return ADDR_W'({pair, ptr});
  endfunction

  function automatic logic [7:0] level_sat(input ptr_t fill);
    if (32'(fill) > 32'd255) begin
      return 8'hFF;
    end
    return 8'(fill);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pcf_ram.sv =====
`default_nettype none

module pcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/pty_channel_pair_fifo.sv =====
`default_nettype none

// pseudo-terminal channel pair block
// command port: a transaction is taken at a rising edge with start_i high and busy_o low.
// operation_i selects alloc, a byte write or read on the master or slave side, or a close.
// pair_select_i addresses the pair (ignored for alloc); write_byte_i, nonblock_i and
// last_of_call_i travel with the command.
// result port: done_o is high for exactly one cycle with status_o, read_byte_o, accepted_o,
// allocated_pair_o, master_level_o, slave_level_o and last_out_o valid in that cycle.
// the receiver cannot stall; the result is taken at the edge that ends the done_o cycle.
// steps: the command is registered, run in S_EXEC, and in S_RESP the read byte, the levels
// and done_o are registered; a slave-side line feed write that first stores a carriage return adds S_LF.
// commands do not overlap: busy_o stays high from the taken command until its done_o cycle,
// set by the registered read of the byte stores and the single write port per store.
// busy_o drops in the done_o cycle, so the next command can be taken at its closing edge.
// reset: all pairs free, ring pointers and closed flags zero; the byte stores are not
// cleared, a ring only returns bytes written since its pair was allocated.

module pty_channel_pair_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [2:0] operation_i,
  input  wire logic [1:0] pair_select_i,
  input  wire logic [7:0] write_byte_i,
  input  wire logic       nonblock_i,
  input  wire logic       last_of_call_i,
  output logic            done_o,
  output logic      [2:0] status_o,
  output logic      [7:0] read_byte_o,
  output logic            accepted_o,
  output logic      [1:0] allocated_pair_o,
  output logic      [7:0] master_level_o,
  output logic      [7:0] slave_level_o,
  output logic            last_out_o
);

  import pcf_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  ptr_t m_head_q [PAIR_COUNT];
  ptr_t m_head_d [PAIR_COUNT];
  ptr_t m_tail_q [PAIR_COUNT];
  ptr_t m_tail_d [PAIR_COUNT];
  ptr_t s_head_q [PAIR_COUNT];
  ptr_t s_head_d [PAIR_COUNT];
  ptr_t s_tail_q [PAIR_COUNT];
  ptr_t s_tail_d [PAIR_COUNT];
  logic [PAIR_COUNT-1:0] in_use_q, in_use_d;
  logic [PAIR_COUNT-1:0] m_closed_q, m_closed_d;
  logic [PAIR_COUNT-1:0] s_closed_q, s_closed_d;

  logic [2:0] op_q, op_d;
  pidx_t      idx_q, idx_d;
  logic       in_range_q, in_range_d;
  logic [7:0] wbyte_q, wbyte_d;
  logic       nb_q, nb_d;
  logic       last_q, last_d;
  status_e    res_status_q, res_status_d;
  logic       res_acc_q, res_acc_d;
  logic [1:0] res_apair_q, res_apair_d;
  logic       lvl_en_q, lvl_en_d;
  logic       rd_ok_q, rd_ok_d;
  logic       rd_master_q, rd_master_d;
  logic [7:0] read_byte_q, read_byte_d;
  logic [7:0] m_level_q, m_level_d;
  logic [7:0] s_level_q, s_level_d;

  logic       lf_pending;
  logic       tm_we, ts_we;
  addr_t      tm_waddr, ts_waddr, tm_raddr, ts_raddr;
  logic [7:0] tm_wdata, ts_wdata, tm_rdata, ts_rdata;

  logic       pair_ok;
  logic       mine, peer;
  ptr_t       m_fill, s_fill;
  logic       found;
  pidx_t      free_idx;

  pcf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_toward_master (
    .clk_i  (clk_i),
    .we_i   (tm_we),
    .waddr_i(tm_waddr),
    .wdata_i(tm_wdata),
    .raddr_i(tm_raddr),
    .rdata_o(tm_rdata)
  );

  pcf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_toward_slave (
    .clk_i  (clk_i),
    .we_i   (ts_we),
    .waddr_i(ts_waddr),
    .wdata_i(ts_wdata),
    .raddr_i(ts_raddr),
    .rdata_o(ts_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = lf_pending ? S_LF : S_RESP;
      end
      S_LF: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    busy_o = (state_q != S_IDLE);
    done_d = (state_q == S_RESP);
  end

  // lowest free pair
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < PAIR_COUNT; i++) begin
      if (!found && !in_use_q[i]) begin
        found    = 1'b1;
        free_idx = pidx_t'(i);
      end
    end
  end

  // addressed pair view
  always_comb begin
    pair_ok = in_range_q ? in_use_q[idx_q] : 1'b0;
    m_fill  = m_head_q[idx_q] - m_tail_q[idx_q];
    s_fill  = s_head_q[idx_q] - s_tail_q[idx_q];
    if (op_q == OP_MWRITE || op_q == OP_MREAD) begin
      mine = m_closed_q[idx_q];
      peer = s_closed_q[idx_q];
    end else begin
      mine = s_closed_q[idx_q];
      peer = m_closed_q[idx_q];
    end
  end

  // datapath
  always_comb begin
    m_head_d     = m_head_q;
    m_tail_d     = m_tail_q;
    s_head_d     = s_head_q;
    s_tail_d     = s_tail_q;
    in_use_d     = in_use_q;
    m_closed_d   = m_closed_q;
    s_closed_d   = s_closed_q;
    op_d         = op_q;
    idx_d        = idx_q;
    in_range_d   = in_range_q;
    wbyte_d      = wbyte_q;
    nb_d         = nb_q;
    last_d       = last_q;
    res_status_d = res_status_q;
    res_acc_d    = res_acc_q;
    res_apair_d  = res_apair_q;
    lvl_en_d     = lvl_en_q;
    rd_ok_d      = rd_ok_q;
    rd_master_d  = rd_master_q;
    read_byte_d  = read_byte_q;
    m_level_d    = m_level_q;
    s_level_d    = s_level_q;
    lf_pending   = 1'b0;
    tm_we        = 1'b0;
    tm_waddr     = addr_of(idx_q, m_head_q[idx_q]);
    tm_wdata     = wbyte_q;
    tm_raddr     = addr_of(idx_q, m_tail_q[idx_q]);
    ts_we        = 1'b0;
    ts_waddr     = addr_of(idx_q, s_head_q[idx_q]);
    ts_wdata     = wbyte_q;
    ts_raddr     = addr_of(idx_q, s_tail_q[idx_q]);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d       = operation_i;
          idx_d      = pidx_t'(pair_select_i);
          in_range_d = (32'(pair_select_i) < PAIR_COUNT);
          wbyte_d    = write_byte_i;
          nb_d       = nonblock_i;
          last_d     = last_of_call_i;
        end
      end

      S_EXEC: begin
        res_status_d = STAT_OK;
        res_acc_d    = 1'b0;
        res_apair_d  = 2'b00;
        rd_ok_d      = 1'b0;
        rd_master_d  = (op_q == OP_MREAD);
        lvl_en_d     = in_range_q;
        if (op_q == OP_ALLOC) begin
          if (found) begin
            m_head_d[free_idx]   = '0;
            m_tail_d[free_idx]   = '0;
            s_head_d[free_idx]   = '0;
            s_tail_d[free_idx]   = '0;
            m_closed_d[free_idx] = 1'b0;
            s_closed_d[free_idx] = 1'b0;
            in_use_d[free_idx]   = 1'b1;
            res_apair_d          = 2'(free_idx);
            idx_d                = free_idx;
            lvl_en_d             = 1'b1;
          end else begin
            res_status_d = STAT_NONE_FREE;
            lvl_en_d     = 1'b0;
          end
        end else if (!pair_ok) begin
          res_status_d = STAT_BAD_PAIR;
        end else begin
          case (op_q)
            OP_MWRITE: begin
              if (mine) begin
                res_status_d = STAT_OWN_CLOSED;
              end else if (peer) begin
                res_status_d = STAT_PEER_CLOSED;
              end else if (s_fill == FULL_FILL) begin
                res_status_d = STAT_FULL;
              end else begin
                ts_we           = 1'b1;
                s_head_d[idx_q] = s_head_q[idx_q] + 1'b1;
                res_acc_d       = 1'b1;
              end
            end
            OP_SWRITE: begin
              if (mine) begin
                res_status_d = STAT_OWN_CLOSED;
              end else if (peer) begin
                res_status_d = STAT_PEER_CLOSED;
              end else if (m_fill == FULL_FILL) begin
                res_status_d = STAT_FULL;
              end else begin
                tm_we           = 1'b1;
                m_head_d[idx_q] = m_head_q[idx_q] + 1'b1;
                if (wbyte_q == BYTE_LF) begin
                  tm_wdata   = BYTE_CR;
                  lf_pending = 1'b1;
                end else begin
                  res_acc_d = 1'b1;
                end
              end
            end
            OP_MREAD: begin
              if (mine) begin
                res_status_d = STAT_OWN_CLOSED;
              end else if (m_fill == '0) begin
                res_status_d = peer ? STAT_PEER_CLOSED :
                               (nb_q ? STAT_WOULD_BLOCK : STAT_EMPTY);
              end else begin
                m_tail_d[idx_q] = m_tail_q[idx_q] + 1'b1;
                rd_ok_d         = 1'b1;
              end
            end
            OP_SREAD: begin
              if (mine) begin
                res_status_d = STAT_OWN_CLOSED;
              end else if (s_fill == '0) begin
                res_status_d = peer ? STAT_PEER_CLOSED :
                               (nb_q ? STAT_WOULD_BLOCK : STAT_EMPTY);
              end else begin
                s_tail_d[idx_q] = s_tail_q[idx_q] + 1'b1;
                rd_ok_d         = 1'b1;
              end
            end
            OP_MCLOSE: begin
              m_closed_d[idx_q] = 1'b1;
              if (s_closed_q[idx_q]) begin
                in_use_d[idx_q] = 1'b0;
              end
            end
            OP_SCLOSE: begin
              s_closed_d[idx_q] = 1'b1;
              if (m_closed_q[idx_q]) begin
                in_use_d[idx_q] = 1'b0;
              end
            end
            default: begin
              res_status_d = STAT_BAD_PAIR;
            end
          endcase
        end
      end

      // line feed after the inserted carriage return
      S_LF: begin
        if (m_fill == FULL_FILL) begin
          res_status_d = STAT_FULL;
          res_acc_d    = 1'b0;
        end else begin
          tm_we           = 1'b1;
          m_head_d[idx_q] = m_head_q[idx_q] + 1'b1;
          res_status_d    = STAT_OK;
          res_acc_d       = 1'b1;
        end
      end

      S_RESP: begin
        if (rd_ok_q) begin
          read_byte_d = rd_master_q ? tm_rdata : ts_rdata;
        end else begin
          read_byte_d = 8'h00;
        end
        if (lvl_en_q && in_use_q[idx_q]) begin
          m_level_d = level_sat(m_fill);
          s_level_d = level_sat(s_fill);
        end else begin
          m_level_d = 8'h00;
          s_level_d = 8'h00;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      in_use_q   <= '0;
      m_closed_q <= '0;
      s_closed_q <= '0;
      for (int i = 0; i < PAIR_COUNT; i++) begin
        m_head_q[i] <= '0;
        m_tail_q[i] <= '0;
        s_head_q[i] <= '0;
        s_tail_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      in_use_q   <= in_use_d;
      m_closed_q <= m_closed_d;
      s_closed_q <= s_closed_d;
      m_head_q   <= m_head_d;
      m_tail_q   <= m_tail_d;
      s_head_q   <= s_head_d;
      s_tail_q   <= s_tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    in_range_q   <= in_range_d;
    wbyte_q      <= wbyte_d;
    nb_q         <= nb_d;
    last_q       <= last_d;
    res_status_q <= res_status_d;
    res_acc_q    <= res_acc_d;
    res_apair_q  <= res_apair_d;
    lvl_en_q     <= lvl_en_d;
    rd_ok_q      <= rd_ok_d;
    rd_master_q  <= rd_master_d;
    read_byte_q  <= read_byte_d;
    m_level_q    <= m_level_d;
    s_level_q    <= s_level_d;
  end

  assign done_o           = done_q;
  assign status_o         = res_status_q;
  assign read_byte_o      = read_byte_q;
  assign accepted_o       = res_acc_q;
  assign allocated_pair_o = res_apair_q;
  assign master_level_o   = m_level_q;
  assign slave_level_o    = s_level_q;
  assign last_out_o       = last_q;

  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_RESP))
    else $error("result strobe without a response cycle");

  a_start_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_EXEC))
    else $error("taken command did not enter execution");

  a_lf_only_on_slave_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LF) |-> (op_q == OP_SWRITE && wbyte_q == BYTE_LF))
    else $error("line feed cycle for a command that is not a slave line feed write");

  a_accept_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (status_o == STAT_OK))
    else $error("byte stored but status is not ok");

  a_single_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tm_we && ts_we))
    else $error("both byte stores written in one cycle");

endmodule

`default_nettype wire

// ===== tb/sv/tb_pty_channel_pair_fifo.sv =====
`timescale 1ns / 1ps

module tb_pty_channel_pair_fifo;
  import pcf_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int ITEM_TARGET = 1330;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] pair;
    logic [7:0] wbyte;
    logic       nb;
    logic       last;
  } pty_cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] rbyte;
    logic       acc;
    logic [1:0] apair;
    logic [7:0] mlvl;
    logic [7:0] slvl;
    logic       last;
  } pty_rsp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [2:0] operation_i = '0;
  logic [1:0] pair_select_i = '0;
  logic [7:0] write_byte_i = '0;
  logic       nonblock_i = 1'b0;
  logic       last_of_call_i = 1'b0;
  logic       busy_o;
  logic       done_o;
  logic [2:0] status_o;
  logic [7:0] read_byte_o;
  logic       accepted_o;
  logic [1:0] allocated_pair_o;
  logic [7:0] master_level_o;
  logic [7:0] slave_level_o;
  logic       last_out_o;

  pty_channel_pair_fifo i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .pair_select_i    (pair_select_i),
    .write_byte_i     (write_byte_i),
    .nonblock_i       (nonblock_i),
    .last_of_call_i   (last_of_call_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .read_byte_o      (read_byte_o),
    .accepted_o       (accepted_o),
    .allocated_pair_o (allocated_pair_o),
    .master_level_o   (master_level_o),
    .slave_level_o    (slave_level_o),
    .last_out_o       (last_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted channel pair state
  logic [7:0] tm_mem [PAIR_COUNT][RING_BYTES];
  logic [7:0] ts_mem [PAIR_COUNT][RING_BYTES];
  ptr_t       tm_head [PAIR_COUNT];
  ptr_t       tm_tail [PAIR_COUNT];
  ptr_t       ts_head [PAIR_COUNT];
  ptr_t       ts_tail [PAIR_COUNT];
  logic       pair_open [PAIR_COUNT];
  logic       mside_shut [PAIR_COUNT];
  logic       sside_shut [PAIR_COUNT];

  pty_cmd_t cmd_backlog_q[$];
  pty_rsp_t rsp_due_q[$];
  int       pushed_cnt = 0;
  int       accepted_cnt = 0;
  int       err_cnt = 0;
  int       quiet_cycles = 0;
  int       gap_left = 0;
  int       burst_left = 1;

  initial begin
    for (int i = 0; i < PAIR_COUNT; i++) begin
      tm_head[i] = '0;
      tm_tail[i] = '0;
      ts_head[i] = '0;
      ts_tail[i] = '0;
      pair_open[i] = 1'b0;
      mside_shut[i] = 1'b0;
      sside_shut[i] = 1'b0;
    end
  end

  function automatic ptr_t ring_count(input ptr_t h, input ptr_t t);
    return ptr_t'(h - t);
  endfunction

  task automatic push_toward_master(input int p, input logic [7:0] b, output logic ok);
    ok = (ring_count(tm_head[p], tm_tail[p]) != FULL_FILL);
    if (ok) begin
      tm_mem[p][tm_head[p]] = b;
      tm_head[p] = tm_head[p] + 1'b1;
    end
  endtask

  task automatic model_pty_cmd(input pty_cmd_t c, output pty_rsp_t r);
    int   lp;
    logic mine;
    logic peer;
    logic stored;
    logic avail;
    r = '0;
    r.status = STAT_OK;
    r.last = c.last;
    lp = int'(c.pair);
    if (c.op == OP_ALLOC) begin
      lp = PAIR_COUNT;
      for (int i = PAIR_COUNT - 1; i >= 0; i--) begin
        if (!pair_open[i]) lp = i;
      end
      if (lp == PAIR_COUNT) begin
        r.status = STAT_NONE_FREE;
      end else begin
        tm_head[lp] = '0;
        tm_tail[lp] = '0;
        ts_head[lp] = '0;
        ts_tail[lp] = '0;
        mside_shut[lp] = 1'b0;
        sside_shut[lp] = 1'b0;
        pair_open[lp] = 1'b1;
        r.apair = 2'(lp);
      end
    end else if (c.op == OP_UNUSED || lp >= PAIR_COUNT || !pair_open[lp]) begin
      r.status = STAT_BAD_PAIR;
    end else begin
      mine = (c.op == OP_MWRITE || c.op == OP_MREAD) ? mside_shut[lp] : sside_shut[lp];
      peer = (c.op == OP_MWRITE || c.op == OP_MREAD) ? sside_shut[lp] : mside_shut[lp];
      case (c.op)
        OP_MWRITE, OP_SWRITE: begin
          if (mine) begin
            r.status = STAT_OWN_CLOSED;
          end else if (peer) begin
            r.status = STAT_PEER_CLOSED;
          end else begin
            if (c.op == OP_MWRITE) begin
              stored = (ring_count(ts_head[lp], ts_tail[lp]) != FULL_FILL);
              if (stored) begin
                ts_mem[lp][ts_head[lp]] = c.wbyte;
                ts_head[lp] = ts_head[lp] + 1'b1;
              end
            end else begin
              // line feed goes out as cr lf, the cr stays even if the lf is refused
              if (c.wbyte == BYTE_LF) push_toward_master(lp, BYTE_CR, stored);
              push_toward_master(lp, c.wbyte, stored);
            end
            r.acc = stored;
            if (!stored) r.status = STAT_FULL;
          end
        end
        OP_MREAD, OP_SREAD: begin
          if (mine) begin
            r.status = STAT_OWN_CLOSED;
          end else begin
            if (c.op == OP_MREAD) begin
              avail = (ring_count(tm_head[lp], tm_tail[lp]) != '0);
              if (avail) begin
                r.rbyte = tm_mem[lp][tm_tail[lp]];
                tm_tail[lp] = tm_tail[lp] + 1'b1;
              end
            end else begin
              avail = (ring_count(ts_head[lp], ts_tail[lp]) != '0);
              if (avail) begin
                r.rbyte = ts_mem[lp][ts_tail[lp]];
                ts_tail[lp] = ts_tail[lp] + 1'b1;
              end
            end
            if (!avail) begin
              if (peer) r.status = STAT_PEER_CLOSED;
              else if (c.nb) r.status = STAT_WOULD_BLOCK;
              else r.status = STAT_EMPTY;
            end
          end
        end
        OP_MCLOSE: begin
          mside_shut[lp] = 1'b1;
          if (sside_shut[lp]) pair_open[lp] = 1'b0;
        end
        default: begin
          sside_shut[lp] = 1'b1;
          if (mside_shut[lp]) pair_open[lp] = 1'b0;
        end
      endcase
    end
    if (lp < PAIR_COUNT && pair_open[lp]) begin
      r.mlvl = ring_count(tm_head[lp], tm_tail[lp]);
      r.slvl = ring_count(ts_head[lp], ts_tail[lp]);
    end
  endtask

  // driver: bursts of commands with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    pty_cmd_t nxt;
    pty_cmd_t took;
    pty_rsp_t due;
    if (!rst_ni) begin
      start_i <= 1'b0;
      operation_i <= '0;
      pair_select_i <= '0;
      write_byte_i <= '0;
      nonblock_i <= 1'b0;
      last_of_call_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        took.op = operation_i;
        took.pair = pair_select_i;
        took.wbyte = write_byte_i;
        took.nb = nonblock_i;
        took.last = last_of_call_i;
        model_pty_cmd(took, due);
        rsp_due_q.push_back(due);
        accepted_cnt++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (cmd_backlog_q.size() > 0) begin
          nxt = cmd_backlog_q.pop_front();
          start_i <= 1'b1;
          operation_i <= nxt.op;
          pair_select_i <= nxt.pair;
          write_byte_i <= nxt.wbyte;
          nonblock_i <= nxt.nb;
          last_of_call_i <= nxt.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            if ($urandom_range(0, 3) == 0) gap_left <= 0;
            else gap_left <= $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every done_o cycle carries one transaction result
  always @(posedge clk_i) begin
    pty_rsp_t got;
    pty_rsp_t want;
    if (rst_ni && done_o) begin
      got.status = status_e'(status_o);
      got.rbyte = read_byte_o;
      got.acc = accepted_o;
      got.apair = allocated_pair_o;
      got.mlvl = master_level_o;
      got.slvl = slave_level_o;
      got.last = last_out_o;
      if (rsp_due_q.size() == 0) begin
        if (err_cnt < 10) $display("%0t: result with none outstanding, status %0d", $time,
                                   status_o);
        err_cnt++;
      end else begin
        want = rsp_due_q.pop_front();
        if (got !== want) begin
          if (err_cnt < 10) begin
            $display("%0t: mismatch exp status %0d rbyte %h acc %0d apair %0d mlvl %0d",
                     $time, want.status, want.rbyte, want.acc, want.apair, want.mlvl,
                     " slvl %0d last %0d", want.slvl, want.last);
            $display("%0t:          got status %0d rbyte %h acc %0d apair %0d mlvl %0d",
                     $time, got.status, got.rbyte, got.acc, got.apair, got.mlvl,
                     " slvl %0d last %0d", got.slvl, got.last);
          end
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input int p, input logic [7:0] b,
                           input logic nb, input logic last);
    pty_cmd_t c;
    c.op = op;
    c.pair = 2'(p);
    c.wbyte = b;
    c.nb = nb;
    c.last = last;
    cmd_backlog_q.push_back(c);
    pushed_cnt++;
  endtask

  task automatic queue_any(input logic [2:0] op, input int p, input logic [7:0] b);
    queue_cmd(op, p, b, 1'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_cnt) @(negedge clk_i);
  endtask

  function automatic int live_pair();
    int cand[$];
    for (int i = 0; i < PAIR_COUNT; i++) begin
      if (pair_open[i] && !mside_shut[i] && !sside_shut[i]) cand.push_back(i);
    end
    if (cand.size() == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, PAIR_COUNT - 1);
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 5) == 0) return BYTE_LF;
    return 8'($urandom);
  endfunction

  function automatic logic [2:0] traffic_op();
    case ($urandom_range(0, 15))
      0, 1, 2, 3:     return OP_MWRITE;
      4, 5, 6, 7:     return OP_SWRITE;
      8, 9, 10, 11:   return OP_MREAD;
      12, 13, 14:     return OP_SREAD;
      default:        return 3'($urandom);
    endcase
  endfunction

  initial begin
    int         kind;
    int         p;
    int         n;
    logic [7:0] b;
    logic [2:0] op;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: unallocated pair, unused code, exhausting the pairs
    queue_cmd(OP_MREAD, 0, 8'h00, 1'b0, 1'b1);
    queue_cmd(OP_UNUSED, 3, 8'hFF, 1'b1, 1'b0);
    repeat (PAIR_COUNT + 1) queue_cmd(OP_ALLOC, 3, 8'h55, 1'b0, 1'b1);
    // byte extremes through the master to slave ring, then empty reads
    queue_cmd(OP_MWRITE, 0, 8'h00, 1'b0, 1'b0);
    queue_cmd(OP_MWRITE, 0, 8'hFF, 1'b1, 1'b1);
    queue_cmd(OP_SREAD, 0, 8'h00, 1'b0, 1'b0);
    queue_cmd(OP_SREAD, 0, 8'hFF, 1'b1, 1'b1);
    queue_cmd(OP_SREAD, 0, 8'h00, 1'b0, 1'b0);
    queue_cmd(OP_SREAD, 0, 8'h00, 1'b1, 1'b1);
    // cr insertion on a slave line feed
    queue_cmd(OP_SWRITE, 1, BYTE_LF, 1'b0, 1'b0);
    queue_cmd(OP_MREAD, 1, 8'h00, 1'b0, 1'b1);
    queue_cmd(OP_MREAD, 1, 8'h00, 1'b1, 1'b0);
    // closed sides, end of file, double close, freeing
    queue_cmd(OP_MCLOSE, 2, 8'h00, 1'b0, 1'b1);
    queue_cmd(OP_MWRITE, 2, 8'hA5, 1'b0, 1'b0);
    queue_cmd(OP_SWRITE, 2, 8'h5A, 1'b1, 1'b1);
    queue_cmd(OP_SREAD, 2, 8'h00, 1'b1, 1'b0);
    queue_cmd(OP_MREAD, 2, 8'h00, 1'b0, 1'b1);
    queue_cmd(OP_MCLOSE, 2, 8'h00, 1'b0, 1'b0);
    queue_cmd(OP_SCLOSE, 2, 8'h00, 1'b1, 1'b1);
    queue_cmd(OP_MREAD, 2, 8'h00, 1'b0, 1'b0);
    queue_cmd(OP_UNUSED, 1, 8'h00, 1'b0, 1'b1);

    while (pushed_cnt < ITEM_TARGET) begin
      settle();
      kind = $urandom_range(0, 39);
      p = live_pair();
      if (kind == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          // fill toward master to one short of full, then a line feed
          n = 254 - int'(ring_count(tm_head[p], tm_tail[p]));
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (b == BYTE_LF) b = b ^ 8'h01;
            queue_any(OP_SWRITE, p, b);
          end
          queue_any(OP_SWRITE, p, BYTE_LF);
          repeat ($urandom_range(1, 3)) queue_any(OP_SWRITE, p, text_byte());
        end else begin
          n = 255 - int'(ring_count(ts_head[p], ts_tail[p])) + $urandom_range(1, 3);
          for (int i = 0; i < n; i++) queue_any(OP_MWRITE, p, 8'($urandom));
        end
      end else if (kind <= 3) begin
        if ($urandom_range(0, 1) == 1) begin
          n = int'(ring_count(tm_head[p], tm_tail[p])) + $urandom_range(1, 2);
          for (int i = 0; i < n; i++) queue_any(OP_MREAD, p, 8'($urandom));
        end else begin
          n = int'(ring_count(ts_head[p], ts_tail[p])) + $urandom_range(1, 2);
          for (int i = 0; i < n; i++) queue_any(OP_SREAD, p, 8'($urandom));
        end
      end else if (kind <= 6) begin
        repeat ($urandom_range(1, 2)) queue_any(OP_ALLOC, $urandom_range(0, PAIR_COUNT - 1),
                                                8'($urandom));
      end else if (kind <= 9) begin
        op = ($urandom_range(0, 1) == 1) ? OP_MCLOSE : OP_SCLOSE;
        queue_any(op, p, 8'($urandom));
        if ($urandom_range(0, 1) == 1) begin
          queue_any((op == OP_MCLOSE) ? OP_SCLOSE : OP_MCLOSE, p, 8'($urandom));
        end
      end else if (kind <= 11) begin
        repeat ($urandom_range(1, 4)) queue_any(3'($urandom), $urandom_range(0, PAIR_COUNT - 1),
                                                8'($urandom));
      end else if (kind <= 15) begin
        // one side shut, the pair still poked from both sides
        op = ($urandom_range(0, 1) == 1) ? OP_MCLOSE : OP_SCLOSE;
        queue_any(op, p, 8'($urandom));
        repeat ($urandom_range(2, 6)) queue_any(traffic_op(), p, text_byte());
        if ($urandom_range(0, 1) == 1) begin
          queue_any((op == OP_MCLOSE) ? OP_SCLOSE : OP_MCLOSE, p, 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 12)) queue_any(traffic_op(), p, text_byte());
      end
    end

    while (accepted_cnt != pushed_cnt || rsp_due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pcf_pkg.sv
hdl/pcf_ram.sv
hdl/pty_channel_pair_fifo.sv
tb/sv/tb_pty_channel_pair_fifo.sv
